/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// consequence holds in the same cycle as the cause
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the cause
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/clnib_pkg.sv */
// ----------------------------------------------------------------------------
// clnib_pkg
// types, codes and constant tables of the character lcd nibble interface
// ----------------------------------------------------------------------------
`default_nettype none

package clnib_pkg;

    // command codes on the func field
    localparam logic [1:0] FuncInit   = 2'd0;
    localparam logic [1:0] FuncWrite  = 2'd1;
    localparam logic [1:0] FuncCursor = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CfgPowerUp   = 2'd0;
    localparam logic [1:0] CfgInitStep  = 2'd1;
    localparam logic [1:0] CfgEnableHi  = 2'd2;
    localparam logic [1:0] CfgClearWait = 2'd3;

    // configuration reset values
    localparam logic [7:0] RstPowerUp   = 8'd50;
    localparam logic [7:0] RstInitStep  = 8'd5;
    localparam logic [7:0] RstEnableHi  = 8'd1;
    localparam logic [7:0] RstClearWait = 8'd2;

    // sequencer step marks
    localparam logic [4:0] BareStart    = 5'd1;
    localparam logic [4:0] CmdStart     = 5'd9;
    localparam logic [4:0] LastByteStep = 5'd3;
    localparam logic [4:0] LastInitStep = 5'd28;
    localparam logic [2:0] ClearCmdIdx  = 3'd2;

    // bare init nibbles
    localparam logic [3:0] BareNib     = 4'h3;
    localparam logic [3:0] BareLastNib = 4'h2;
    localparam logic [1:0] BareLastIdx = 2'd3;

    localparam logic [7:0] SetAddrCmd = 8'h80;

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] byte_val;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    typedef struct packed {
        logic [7:0] power_up_wait_ms;
        logic [7:0] init_step_wait_ms;
        logic [7:0] enable_high_ms;
        logic [7:0] clear_wait_ms;
    } t_cfg;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0: r = 8'h28;
            3'd1: r = 8'h08;
            3'd2: r = 8'h01;
            3'd3: r = 8'h06;
            3'd4: r = 8'h0C;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] r;
        case (row)
            2'd0: r = 8'h00;
            2'd1: r = 8'h40;
            2'd2: r = 8'h14;
            2'd3: r = 8'h54;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/clnib_if.sv */
// ----------------------------------------------------------------------------
// clnib_if
// valid/ready channels for command words and pin state words
// ----------------------------------------------------------------------------
`default_nettype none

interface clnib_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] value;
    logic       is_data;
    logic [5:0] column;
    logic [1:0] row;

    modport source (output valid, func, value, is_data, column, row, input ready);
    modport sink   (input valid, func, value, is_data, column, row, output ready);
endinterface

interface clnib_pin_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       enable;
    logic [3:0] nibble;
    logic [7:0] hold_ms;
    logic       last;

    modport source (output valid, reg_select, enable, nibble, hold_ms, last, input ready);
    modport sink   (input valid, reg_select, enable, nibble, hold_ms, last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/char_lcd_nibble_interface.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface
// character lcd controller for a 4-bit bus, command words in, pin states out
// ----------------------------------------------------------------------------
// Each accepted command word yields a run of pin state words, one per clock
// when the sink keeps ready high: 29 for the init sequence, 4 for a byte
// write or a cursor move, none for an unknown code. The back sequencer
// emits one state per cycle while the sink is ready, so a command holds it
// until its last state is emitted; a QUEUE_DEPTH entry command queue lets
// new words be taken meanwhile. Configuration registers should be written
// only while no command is in flight.
`default_nettype none

module char_lcd_nibble_interface #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    clnib_cmd_if.sink       i_cmd,
    clnib_pin_if.source     o_pin,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);

    clnib_pkg::t_cfg  r_cfg;
    clnib_pkg::t_cmd  push_cmd;
    clnib_pkg::t_head head;
    logic             push;
    logic             pop;
    logic             full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_up_wait_ms  <= clnib_pkg::RstPowerUp;
            r_cfg.init_step_wait_ms <= clnib_pkg::RstInitStep;
            r_cfg.enable_high_ms    <= clnib_pkg::RstEnableHi;
            r_cfg.clear_wait_ms     <= clnib_pkg::RstClearWait;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                clnib_pkg::CfgPowerUp:   r_cfg.power_up_wait_ms  <= i_cfg_data;
                clnib_pkg::CfgInitStep:  r_cfg.init_step_wait_ms <= i_cfg_data;
                clnib_pkg::CfgEnableHi:  r_cfg.enable_high_ms    <= i_cfg_data;
                clnib_pkg::CfgClearWait: r_cfg.clear_wait_ms     <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    clnib_front u_front (
        .i_cmd      (i_cmd),
        .i_full     (full),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    clnib_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_full     (full),
        .o_head     (head)
    );

    clnib_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_cfg   (r_cfg),
        .o_pop   (pop),
        .o_pin   (o_pin)
    );

endmodule

`default_nettype wire

/* hw/rtl/clnib_front.sv */
// ----------------------------------------------------------------------------
// clnib_front
// accepts command words and turns them into byte descriptors for the queue
// ----------------------------------------------------------------------------
`default_nettype none

module clnib_front (
    clnib_cmd_if.sink       i_cmd,
    input  wire logic       i_full,
    output logic            o_push,
    output clnib_pkg::t_cmd o_push_cmd
);

    logic known;

    assign known = (i_cmd.func == clnib_pkg::FuncInit)
                || (i_cmd.func == clnib_pkg::FuncWrite)
                || (i_cmd.func == clnib_pkg::FuncCursor);

    assign i_cmd.ready = !i_full;
    // unknown codes are taken and dropped
    assign o_push = i_cmd.valid && !i_full && known;

    always_comb begin
        o_push_cmd.is_init = (i_cmd.func == clnib_pkg::FuncInit);
        o_push_cmd.rs      = (i_cmd.func == clnib_pkg::FuncWrite) && i_cmd.is_data;
        if (i_cmd.func == clnib_pkg::FuncCursor) begin
            o_push_cmd.byte_val = clnib_pkg::SetAddrCmd
                                | (8'(i_cmd.column) + clnib_pkg::row_base(i_cmd.row));
        end else begin
            o_push_cmd.byte_val = i_cmd.value;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/clnib_queue.sv */
// ----------------------------------------------------------------------------
// clnib_queue
// short fifo of byte descriptors between front and back
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module clnib_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire clnib_pkg::t_cmd  i_push_cmd,
    input  wire logic             i_pop,
    output logic                  o_full,
    output clnib_pkg::t_head      o_head
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    clnib_pkg::t_cmd r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count,  n_count;

    assign o_full       = (r_count == CntW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    `ASSERT_ALWAYS(a_count_max, r_count <= CntW'(DEPTH), "queue count beyond depth")
    `ASSERT_IMPLIES(a_no_overflow, i_push, !o_full, "push into full queue")
    `ASSERT_IMPLIES(a_no_underflow, i_pop, r_count != '0, "pop from empty queue")

endmodule

`default_nettype wire

/* hw/rtl/clnib_back.sv */
// ----------------------------------------------------------------------------
// clnib_back
// steps through the pin states of the command at the queue head
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module clnib_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire clnib_pkg::t_head  i_head,
    input  wire clnib_pkg::t_cfg   i_cfg,
    output logic                   o_pop,
    clnib_pin_if.source            o_pin
);

    logic [4:0] r_step, n_step;
    logic [3:0] r_lines;
    logic       r_o_valid;
    logic       r_o_sel;
    logic       r_o_en;
    logic [3:0] r_o_nib;
    logic [7:0] r_o_hold;
    logic       r_o_last;

    logic       advance;
    logic       is_init;
    logic [4:0] bare_step;
    logic [4:0] byte_step;
    logic [2:0] cmd_idx;
    logic [7:0] byte_val;
    logic       c_sel;
    logic       c_en;
    logic [3:0] c_nib;
    logic [7:0] c_hold;
    logic       c_last;

    assign is_init = i_head.cmd.is_init;
    assign advance = i_head.valid && (!r_o_valid || o_pin.ready);
    assign o_pop   = advance && c_last;

    always_comb begin
        bare_step = r_step - clnib_pkg::BareStart;
        byte_step = is_init ? (r_step - clnib_pkg::CmdStart) : r_step;
        cmd_idx   = byte_step[4:2];
        byte_val  = is_init ? clnib_pkg::init_cmd(cmd_idx) : i_head.cmd.byte_val;
        c_sel     = is_init ? 1'b0 : i_head.cmd.rs;
        c_en      = ~byte_step[0];
        c_nib     = byte_step[1] ? byte_val[3:0] : byte_val[7:4];
        if (c_en) begin
            c_hold = i_cfg.enable_high_ms;
        end else if (is_init && cmd_idx == clnib_pkg::ClearCmdIdx && byte_step[1]) begin
            c_hold = i_cfg.clear_wait_ms;
        end else begin
            c_hold = '0;
        end
        if (is_init && r_step == '0) begin
            // power-up wait keeps the lines as they were
            c_en   = 1'b0;
            c_nib  = r_lines;
            c_hold = i_cfg.power_up_wait_ms;
        end else if (is_init && r_step < clnib_pkg::CmdStart) begin
            c_en   = ~bare_step[0];
            c_nib  = (bare_step[2:1] == clnib_pkg::BareLastIdx) ?
                     clnib_pkg::BareLastNib : clnib_pkg::BareNib;
            c_hold = c_en ? i_cfg.enable_high_ms : i_cfg.init_step_wait_ms;
        end
        c_last = is_init ? (r_step == clnib_pkg::LastInitStep)
                         : (r_step == clnib_pkg::LastByteStep);
        n_step = c_last ? '0 : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_lines   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_step    <= n_step;
                r_lines   <= c_nib;
                r_o_valid <= 1'b1;
            end else if (o_pin.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_sel  <= c_sel;
            r_o_en   <= c_en;
            r_o_nib  <= c_nib;
            r_o_hold <= c_hold;
            r_o_last <= c_last;
        end
    end

    assign o_pin.valid      = r_o_valid;
    assign o_pin.reg_select = r_o_sel;
    assign o_pin.enable     = r_o_en;
    assign o_pin.nibble     = r_o_nib;
    assign o_pin.hold_ms    = r_o_hold;
    assign o_pin.last       = r_o_last;

    `ASSERT_ALWAYS(a_step_max, r_step <= clnib_pkg::LastInitStep, "step beyond init length")
    `ASSERT_ALWAYS(a_byte_steps, is_init || r_step <= clnib_pkg::LastByteStep, "byte overrun")
    `ASSERT_NEXT(a_pop_restart, o_pop, r_step == '0 && r_o_valid && r_o_last, "no restart")

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the character lcd nibble interface
// ----------------------------------------------------------------------------
// Feeds command words: a directed table first, then random commands over
// several register settings. A local model of the lcd bus works out the pin
// state words of each accepted command, and every word that leaves the block
// is checked field by field against the oldest one expected. The command side
// sends in bursts with gaps; the pin side stalls on modes of its own.
// ----------------------------------------------------------------------------

module tb;

    localparam logic [1:0] FuncNone    = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         IDLE_TAIL   = 64;
    localparam int         PHASE_WORDS = 75;
    localparam int         NUM_ROWS    = 21;

    localparam logic [3:0] WAKE_NIB  = 4'h3;
    localparam logic [3:0] MODE4_NIB = 4'h2;
    localparam logic [7:0] CLEAR_CMD = 8'h01;
    localparam logic [7:0] SETUP_SEQ [5] = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
    localparam logic [7:0] ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] value;
        logic       is_data;
        logic [5:0] column;
        logic [1:0] row;
    } t_cmd_word;

    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] nib;
        logic [7:0] hold;
        logic       last;
    } t_pin_word;

    typedef struct {
        logic [1:0] func;
        logic [7:0] value;
        logic       is_data;
        logic [5:0] column;
        logic [1:0] row;
        bit         typed;
        logic       exp_rs;
        logic [7:0] exp_bus;
    } t_stim_row;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} t_rx_mode;

    // func, value, is_data, column, row, typed, rs on bus, byte on bus
    t_stim_row dir_rows [NUM_ROWS] = '{
        '{clnib_pkg::FuncWrite,  8'h00, 1'b0, 6'd0,  2'd0, 1'b1, 1'b0, 8'h00},
        '{clnib_pkg::FuncWrite,  8'hFF, 1'b1, 6'd0,  2'd0, 1'b1, 1'b1, 8'hFF},
        '{clnib_pkg::FuncInit,   8'hFF, 1'b1, 6'd63, 2'd3, 1'b0, 1'b0, 8'h00},
        '{clnib_pkg::FuncCursor, 8'h00, 1'b0, 6'd0,  2'd0, 1'b1, 1'b0, 8'h80},
        '{clnib_pkg::FuncCursor, 8'h00, 1'b0, 6'd63, 2'd3, 1'b1, 1'b0, 8'h93},
        '{clnib_pkg::FuncCursor, 8'h00, 1'b0, 6'd63, 2'd1, 1'b1, 1'b0, 8'hFF},
        '{clnib_pkg::FuncCursor, 8'h00, 1'b0, 6'd45, 2'd3, 1'b0, 1'b0, 8'h00},
        '{clnib_pkg::FuncCursor, 8'hFF, 1'b1, 6'd20, 2'd2, 1'b0, 1'b0, 8'h00},
        '{FuncNone,              8'hFF, 1'b1, 6'd63, 2'd3, 1'b0, 1'b0, 8'h00},
        '{clnib_pkg::FuncWrite,  8'hA5, 1'b1, 6'd63, 2'd3, 1'b0, 1'b0, 8'h00},
        '{clnib_pkg::FuncWrite,  8'h5A, 1'b0, 6'd0,  2'd0, 1'b0, 1'b0, 8'h00},
        '{FuncNone,              8'h00, 1'b0, 6'd0,  2'd0, 1'b0, 1'b0, 8'h00},
        '{clnib_pkg::FuncWrite,  8'h3C, 1'b1, 6'd5,  2'd1, 1'b0, 1'b0, 8'h00},
        '{clnib_pkg::FuncInit,   8'h00, 1'b0, 6'd0,  2'd0, 1'b0, 1'b0, 8'h00},
        '{clnib_pkg::FuncWrite,  8'h80, 1'b1, 6'd0,  2'd0, 1'b1, 1'b1, 8'h80},
        '{clnib_pkg::FuncWrite,  8'h01, 1'b1, 6'd0,  2'd0, 1'b1, 1'b1, 8'h01},
        '{clnib_pkg::FuncWrite,  8'h0F, 1'b0, 6'd21, 2'd2, 1'b0, 1'b0, 8'h00},
        '{clnib_pkg::FuncCursor, 8'h00, 1'b0, 6'd1,  2'd2, 1'b0, 1'b0, 8'h00},
        '{FuncNone,              8'h55, 1'b0, 6'd42, 2'd1, 1'b0, 1'b0, 8'h00},
        '{clnib_pkg::FuncCursor, 8'h00, 1'b1, 6'd42, 2'd1, 1'b0, 1'b0, 8'h00},
        '{clnib_pkg::FuncWrite,  8'h7E, 1'b1, 6'd0,  2'd0, 1'b0, 1'b0, 8'h00}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    clnib_cmd_if cmd_if ();
    clnib_pin_if pin_if ();

    char_lcd_nibble_interface u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_pin      (pin_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // lcd bus model
    logic       lcd_rs;
    logic [3:0] lcd_bus;
    logic [7:0] cfg_power_up;
    logic [7:0] cfg_init_step;
    logic [7:0] cfg_enable_hi;
    logic [7:0] cfg_clear_wait;

    t_pin_word pin_scratch [$];
    t_pin_word pin_expect_q [$];

    int       mismatch_count = 0;
    int       pin_seen       = 0;
    int       cycle_count    = 0;
    int       burst_left     = 0;
    bit       tx_calm        = 1'b0;
    logic [15:0] rx_tick     = '0;
    t_rx_mode rx_mode        = RX_OPEN;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic put_pin(input logic en, input logic [7:0] hold);
        pin_scratch.push_back(t_pin_word'{lcd_rs, en, lcd_bus, hold, 1'b0});
    endtask

    task automatic strobe(input logic [3:0] nib, input logic [7:0] low_hold);
        lcd_bus = nib;
        put_pin(1'b1, cfg_enable_hi);
        put_pin(1'b0, low_hold);
    endtask

    task automatic put_byte(input logic [7:0] b, input logic rs, input logic [7:0] tail);
        lcd_rs = rs;
        strobe(b[7:4], 8'd0);
        strobe(b[3:0], tail);
    endtask

    task automatic lcd_predict(input t_cmd_word w);
        logic [7:0] addr;
        pin_scratch.delete();
        case (w.func)
            clnib_pkg::FuncInit: begin
                lcd_rs = 1'b0;
                put_pin(1'b0, cfg_power_up);
                for (int i = 0; i < 4; i++) begin
                    strobe((i == 3) ? MODE4_NIB : WAKE_NIB, cfg_init_step);
                end
                for (int i = 0; i < 5; i++) begin
                    put_byte(SETUP_SEQ[i], 1'b0,
                             (SETUP_SEQ[i] == CLEAR_CMD) ? cfg_clear_wait : 8'd0);
                end
            end
            clnib_pkg::FuncWrite: begin
                put_byte(w.value, w.is_data, 8'd0);
            end
            clnib_pkg::FuncCursor: begin
                addr = {2'b00, w.column} + ROW_OFFSET[w.row];
                put_byte(clnib_pkg::SetAddrCmd | addr, 1'b0, 8'd0);
            end
            default: begin
            end
        endcase
        if (pin_scratch.size() > 0) begin
            pin_scratch[pin_scratch.size() - 1].last = 1'b1;
        end
    endtask

    task automatic send_cmd(input t_cmd_word w, input bit typed, input logic exp_rs,
                            input logic [7:0] exp_bus);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = tx_calm ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        cmd_if.valid   <= 1'b1;
        cmd_if.func    <= w.func;
        cmd_if.value   <= w.value;
        cmd_if.is_data <= w.is_data;
        cmd_if.column  <= w.column;
        cmd_if.row     <= w.row;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        lcd_predict(w);
        if (typed) begin
            // enable-high hold is the reset value in the directed part
            pin_expect_q.push_back(t_pin_word'{exp_rs, 1'b1, exp_bus[7:4],
                                               clnib_pkg::RstEnableHi, 1'b0});
            pin_expect_q.push_back(t_pin_word'{exp_rs, 1'b0, exp_bus[7:4], 8'd0, 1'b0});
            pin_expect_q.push_back(t_pin_word'{exp_rs, 1'b1, exp_bus[3:0],
                                               clnib_pkg::RstEnableHi, 1'b0});
            pin_expect_q.push_back(t_pin_word'{exp_rs, 1'b0, exp_bus[3:0], 8'd0, 1'b1});
        end else begin
            foreach (pin_scratch[i]) pin_expect_q.push_back(pin_scratch[i]);
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            clnib_pkg::CfgPowerUp:   cfg_power_up   = val;
            clnib_pkg::CfgInitStep:  cfg_init_step  = val;
            clnib_pkg::CfgEnableHi:  cfg_enable_hi  = val;
            clnib_pkg::CfgClearWait: cfg_clear_wait = val;
            default: begin
            end
        endcase
    endtask

    task automatic load_cfg(input logic [7:0] pu, input logic [7:0] st,
                            input logic [7:0] eh, input logic [7:0] cw);
        cfg_write(clnib_pkg::CfgPowerUp, pu);
        cfg_write(clnib_pkg::CfgInitStep, st);
        cfg_write(clnib_pkg::CfgEnableHi, eh);
        cfg_write(clnib_pkg::CfgClearWait, cw);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        burst_left = 0;
        while (pin_expect_q.size() > 0) @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    function automatic t_cmd_word rand_cmd();
        t_cmd_word w;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            w.func = clnib_pkg::FuncInit;
        end else if (pick < 55) begin
            w.func = clnib_pkg::FuncWrite;
        end else if (pick < 92) begin
            w.func = clnib_pkg::FuncCursor;
        end else begin
            w.func = FuncNone;
        end
        w.value   = 8'($urandom_range(0, 255));
        w.is_data = 1'($urandom_range(0, 1));
        w.column  = 6'($urandom_range(0, 63));
        w.row     = 2'($urandom_range(0, 3));
        return w;
    endfunction

    // pin side stalls
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 16'd1;
        if (rx_tick[5:0] == 6'd0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_OPEN:     pin_if.ready <= 1'b1;
            RX_RANDOM:   pin_if.ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: pin_if.ready <= (rx_tick[2:0] < 3'd5);
            default:     pin_if.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin : pin_check
        t_pin_word got;
        t_pin_word want;
        if (i_rst_n && pin_if.valid && pin_if.ready) begin
            got = t_pin_word'{pin_if.reg_select, pin_if.enable, pin_if.nibble,
                              pin_if.hold_ms, pin_if.last};
            if (pin_expect_q.size() == 0) begin
                note_mismatch($sformatf("word %0d not expected", pin_seen));
            end else begin
                want = pin_expect_q.pop_front();
                if (got.rs !== want.rs)
                    note_mismatch($sformatf("word %0d reg_select %0b want %0b",
                                            pin_seen, got.rs, want.rs));
                if (got.en !== want.en)
                    note_mismatch($sformatf("word %0d enable %0b want %0b",
                                            pin_seen, got.en, want.en));
                if (got.nib !== want.nib)
                    note_mismatch($sformatf("word %0d nibble %h want %h",
                                            pin_seen, got.nib, want.nib));
                if (got.hold !== want.hold)
                    note_mismatch($sformatf("word %0d hold_ms %0d want %0d",
                                            pin_seen, got.hold, want.hold));
                if (got.last !== want.last)
                    note_mismatch($sformatf("word %0d last %0b want %0b",
                                            pin_seen, got.last, want.last));
            end
            pin_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : main_seq
        t_cmd_word w;
        int sent;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= clnib_pkg::CfgPowerUp;
        i_cfg_data     <= 8'd0;
        cmd_if.valid   <= 1'b0;
        cmd_if.func    <= clnib_pkg::FuncInit;
        cmd_if.value   <= 8'd0;
        cmd_if.is_data <= 1'b0;
        cmd_if.column  <= 6'd0;
        cmd_if.row     <= 2'd0;
        lcd_rs         = 1'b0;
        lcd_bus        = 4'd0;
        cfg_power_up   = clnib_pkg::RstPowerUp;
        cfg_init_step  = clnib_pkg::RstInitStep;
        cfg_enable_hi  = clnib_pkg::RstEnableHi;
        cfg_clear_wait = clnib_pkg::RstClearWait;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            w = '{dir_rows[r].func, dir_rows[r].value, dir_rows[r].is_data,
                  dir_rows[r].column, dir_rows[r].row};
            send_cmd(w, dir_rows[r].typed, dir_rows[r].exp_rs, dir_rows[r].exp_bus);
        end
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_cfg(8'h00, 8'h00, 8'h00, 8'h00);
                1: load_cfg(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                2: load_cfg(8'h00, 8'hFF, 8'h00, 8'hFF);
                3: load_cfg(8'hFF, 8'h00, 8'hFF, 8'h00);
                default: load_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            tx_calm = (ph == 2);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                w = rand_cmd();
                send_cmd(w, 1'b0, 1'b0, 8'h00);
                sent++;
            end
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* char_lcd_nibble_interface.f */
+incdir+hw/rtl
hw/rtl/clnib_pkg.sv
hw/rtl/clnib_if.sv
hw/rtl/clnib_front.sv
hw/rtl/clnib_queue.sv
hw/rtl/clnib_back.sv
hw/rtl/char_lcd_nibble_interface.sv
tb/tb.sv
